@@ rtl/audio_beat_detector_top_assert.svh @@
// assertion macros for the beat detector
// each macro takes a label, a clock, a reset, an antecedent and a consequent
`ifndef AUDIO_BEAT_DETECTOR_TOP_ASSERT_SVH
`define AUDIO_BEAT_DETECTOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ABD_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("beat detector check failed");
`define ABD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("beat detector check failed");
`else
`define ABD_ASSERT_SAME(label, clock, reset, ante, cons)
`define ABD_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

@@ rtl/abd_pkg.sv @@
package abd_pkg;

  // default sizes
  localparam int SAMPLE_BITS_DEF     = 12;
  localparam int FRAC_BITS_DEF       = 8;
  localparam int TICK_COUNT_BITS_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MID_RAIL       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_FACTOR   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_WEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEAT_RATIO     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_MIN       = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS     = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOCKOUT_TICKS  = 3'd7;

  // register reset values
  localparam int MID_RAIL_RESET       = 2048;
  localparam int DECAY_FACTOR_RESET   = 60948;
  localparam int BASE_WEIGHT_RESET    = 66;
  localparam int BEAT_RATIO_RESET     = 384;
  localparam int BASE_MIN_RESET       = 40;
  localparam int HOLD_TICKS_RESET     = 100;
  localparam int LOCKOUT_TICKS_RESET  = 200;

  // baseline after reset, in whole adc counts
  localparam int BASE_RESET_COUNTS = 100;

  // coefficient formats
  localparam int COEF_BITS   = 16;   // q0.16 factors and tick counts
  localparam int RATIO_BITS  = 12;   // q4.8 ratio
  localparam int RATIO_SHIFT = COEF_BITS - RATIO_BITS;
  localparam int LEVEL_BITS  = 12;

  // serial multiplier: two multiplier bits per step
  localparam int DIGIT_BITS  = 2;
  localparam int STEP_BITS   = 3;
  localparam int COEF_STEPS  = COEF_BITS / DIGIT_BITS;
  localparam int RATIO_STEPS = RATIO_BITS / DIGIT_BITS;

  // result word
  localparam int OUT_DATA_BITS = 32;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - 2 - 2 * LEVEL_BITS;

endpackage

@@ rtl/audio_beat_detector_top.sv @@
// Beat detector for a microphone fed at one adc sample per millisecond tick. Each input item
// carries one sample; each produces exactly one result item holding the beat start flag,
// the beat active flag and the integer parts of the envelope and the adaptive baseline.
// Configuration registers must be written through the plain write port while the block is idle
// (the block does not enforce this); clearing enable holds the detector at its reset state and
// makes every result all zero. Every product goes through one shared radix-4 serial multiplier
// (two multiplier bits per cycle): the envelope decay (8 steps, skipped when the sample
// attacks), the baseline update (8 steps) and the threshold product (6 steps), with set-up,
// floor and compare states around them. A sample is taken only in idle, so the next one
// waits until the last result is handed to the output register; a disabled item goes
// straight to the hand-off. A result waiting in the output register does not stop the next
// sample; the sequencer only waits at the hand-off until that register is free.
`include "audio_beat_detector_top_assert.svh"

module audio_beat_detector_top #(
  parameter int SAMPLE_BITS     = abd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS       = abd_pkg::FRAC_BITS_DEF,
  parameter int TICK_COUNT_BITS = abd_pkg::TICK_COUNT_BITS_DEF,
  localparam int IN_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [abd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [abd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // sample items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [IN_DATA_BITS-1:0]             s_tdata,   // sample
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [abd_pkg::OUT_DATA_BITS-1:0]   m_tdata    // beat_start, beat_active,
                                                         // envelope_level, baseline_level
);

  // envelope and baseline width, integer plus fraction
  localparam int V  = SAMPLE_BITS + FRAC_BITS;
  // multiplicand: signed, wide enough for the baseline shifted up for the ratio product
  localparam int AW = V + abd_pkg::RATIO_SHIFT + 1;
  // partial product: room for three times the multiplicand plus the running sum
  localparam int PW = AW + 3;
  // tick compare width
  localparam int CW = (TICK_COUNT_BITS > abd_pkg::COEF_BITS) ?
                      TICK_COUNT_BITS : abd_pkg::COEF_BITS;
  localparam int LW = abd_pkg::LEVEL_BITS;

  localparam logic [V-1:0] BASE_RESET =
    V'(abd_pkg::BASE_RESET_COUNTS) << FRAC_BITS;
  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DECAY = 4'd1;   // envelope times decay factor
  localparam logic [3:0] S_BSET  = 4'd2;   // load envelope minus baseline
  localparam logic [3:0] S_BASE  = 4'd3;   // alpha times the difference
  localparam logic [3:0] S_FLOOR = 4'd4;   // add the correction to the baseline
  localparam logic [3:0] S_RSET  = 4'd5;   // apply the floor, load the ratio product
  localparam logic [3:0] S_RATIO = 4'd6;   // baseline times ratio
  localparam logic [3:0] S_CMP   = 4'd7;   // beat test and lockout
  localparam logic [3:0] S_OUT   = 4'd8;   // hand the result to the output register

  // configuration registers
  logic                   enable;
  logic [SAMPLE_BITS-1:0] mid_rail;
  logic [15:0]            decay_factor;
  logic [15:0]            base_weight;
  logic [11:0]            beat_ratio;
  logic [SAMPLE_BITS-1:0] base_min;
  logic [15:0]            hold_ticks;
  logic [15:0]            lockout_ticks;

  // detector state
  logic [V-1:0]               env;
  logic [V-1:0]               base;
  logic [TICK_COUNT_BITS-1:0] ticks;
  logic                       seen;

  // sequencer and serial multiplier
  logic [3:0]                       state;
  logic [abd_pkg::STEP_BITS-1:0]    step;
  logic signed [AW-1:0]             mul_a;
  logic [abd_pkg::COEF_BITS-1:0]    mul_b;
  logic signed [PW-1:0]             prod;
  logic                             start_flag;
  logic                             zero_out;

  // output register
  logic          out_start;
  logic          out_active;
  logic [LW-1:0] out_env;
  logic [LW-1:0] out_base;

  // combinational helpers
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] diff;
  logic [V-1:0]           amp;
  logic signed [PW-1:0]   pp_lo;
  logic signed [PW-1:0]   pp_hi;
  logic signed [PW-1:0]   sum;
  logic signed [PW-1:0]   prod_next;
  logic                   mul_last;
  logic signed [V:0]      diff_eb;
  logic [V-1:0]           flo;
  logic [V-1:0]           base_f;
  logic [V+abd_pkg::RATIO_SHIFT-1:0] thresh;
  logic                   beat_hit;
  logic                   lock_ok;
  logic                   out_free;
  logic [V+LW-1:0]        env_wide;
  logic [V+LW-1:0]        base_wide;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // amplitude, shifted into the envelope format
  assign sample = s_tdata[SAMPLE_BITS-1:0];
  assign diff   = (sample >= mid_rail) ? (sample - mid_rail) : (mid_rail - sample);
  assign amp    = {diff, {FRAC_BITS{1'b0}}};

  // one radix-4 digit: the running sum shifts right two bits a step, so after all digits
  // it holds the product with the multiplier's fraction bits floored away
  assign pp_lo     = mul_b[0] ? PW'(mul_a) : '0;
  assign pp_hi     = mul_b[1] ? (PW'(mul_a) <<< 1) : '0;
  assign sum       = prod + pp_lo + pp_hi;
  assign prod_next = sum >>> abd_pkg::DIGIT_BITS;
  assign mul_last  = (state == S_RATIO) ?
                     (step == abd_pkg::STEP_BITS'(abd_pkg::RATIO_STEPS - 1)) :
                     (step == abd_pkg::STEP_BITS'(abd_pkg::COEF_STEPS - 1));

  // baseline update is base + alpha * (env - base) / 2^16, floored
  assign diff_eb = $signed({1'b0, env}) - $signed({1'b0, base});
  assign flo     = {base_min, {FRAC_BITS{1'b0}}};
  assign base_f  = (base < flo) ? flo : base;

  // env * 256 > base * ratio  <=>  floor(base * ratio / 256) < env
  assign thresh   = prod[V+abd_pkg::RATIO_SHIFT-1:0];
  assign beat_hit = thresh < {{abd_pkg::RATIO_SHIFT{1'b0}}, env};
  assign lock_ok  = !seen || (CW'(ticks) >= CW'(lockout_ticks));

  // integer parts, masked to the result field
  assign env_wide  = {{LW{1'b0}}, env} >> FRAC_BITS;
  assign base_wide = {{LW{1'b0}}, base} >> FRAC_BITS;

  assign m_tdata = {{abd_pkg::OUT_PAD_BITS{1'b0}}, out_base, out_env, out_active, out_start};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      mid_rail       <= SAMPLE_BITS'(abd_pkg::MID_RAIL_RESET);
      decay_factor   <= 16'(abd_pkg::DECAY_FACTOR_RESET);
      base_weight    <= 16'(abd_pkg::BASE_WEIGHT_RESET);
      beat_ratio     <= 12'(abd_pkg::BEAT_RATIO_RESET);
      base_min       <= SAMPLE_BITS'(abd_pkg::BASE_MIN_RESET);
      hold_ticks     <= 16'(abd_pkg::HOLD_TICKS_RESET);
      lockout_ticks  <= 16'(abd_pkg::LOCKOUT_TICKS_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        abd_pkg::REG_ENABLE:         enable         <= cfg_data[0];
        abd_pkg::REG_MID_RAIL:       mid_rail       <= cfg_data[SAMPLE_BITS-1:0];
        abd_pkg::REG_DECAY_FACTOR:   decay_factor   <= cfg_data[15:0];
        abd_pkg::REG_BASE_WEIGHT:    base_weight    <= cfg_data[15:0];
        abd_pkg::REG_BEAT_RATIO:     beat_ratio     <= cfg_data[11:0];
        abd_pkg::REG_BASE_MIN:       base_min       <= cfg_data[SAMPLE_BITS-1:0];
        abd_pkg::REG_HOLD_TICKS:     hold_ticks     <= cfg_data[15:0];
        abd_pkg::REG_LOCKOUT_TICKS:  lockout_ticks  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, detector state and multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      env        <= '0;
      base       <= BASE_RESET;
      ticks      <= '0;
      seen       <= 1'b0;
      start_flag <= 1'b0;
      zero_out   <= 1'b0;
      prod       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            start_flag <= 1'b0;
            if (!enable) begin
              // disabled: back to reset values, all-zero result
              env      <= '0;
              base     <= BASE_RESET;
              ticks    <= '0;
              seen     <= 1'b0;
              zero_out <= 1'b1;
              state    <= S_OUT;
            end else begin
              zero_out <= 1'b0;
              if (seen && ticks != TICK_MAX) begin
                ticks <= ticks + 1'b1;
              end
              if (amp > env) begin
                // instant attack
                env   <= amp;
                state <= S_BSET;
              end else begin
                mul_a <= AW'($signed({1'b0, env}));
                mul_b <= decay_factor;
                prod  <= '0;
                step  <= '0;
                state <= S_DECAY;
              end
            end
          end
        end
        S_DECAY: begin
          mul_b <= mul_b >> abd_pkg::DIGIT_BITS;
          step  <= step + 1'b1;
          prod  <= prod_next;
          if (mul_last) begin
            env   <= prod_next[V-1:0];
            state <= S_BSET;
          end
        end
        S_BSET: begin
          mul_a <= AW'(diff_eb);
          mul_b <= base_weight;
          prod  <= '0;
          step  <= '0;
          state <= S_BASE;
        end
        S_BASE: begin
          mul_b <= mul_b >> abd_pkg::DIGIT_BITS;
          step  <= step + 1'b1;
          prod  <= prod_next;
          if (mul_last) begin
            state <= S_FLOOR;
          end
        end
        S_FLOOR: begin
          // the sum stays inside the envelope range, so wrapping is harmless
          base  <= base + prod[V-1:0];
          state <= S_RSET;
        end
        S_RSET: begin
          base  <= base_f;
          mul_a <= AW'($signed({1'b0, base_f, {abd_pkg::RATIO_SHIFT{1'b0}}}));
          mul_b <= {{abd_pkg::RATIO_SHIFT{1'b0}}, beat_ratio};
          prod  <= '0;
          step  <= '0;
          state <= S_RATIO;
        end
        S_RATIO: begin
          mul_b <= mul_b >> abd_pkg::DIGIT_BITS;
          step  <= step + 1'b1;
          prod  <= prod_next;
          if (mul_last) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (beat_hit && lock_ok) begin
            start_flag <= 1'b1;
            seen       <= 1'b1;
            ticks      <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      if (zero_out) begin
        out_start  <= 1'b0;
        out_active <= 1'b0;
        out_env    <= '0;
        out_base   <= '0;
      end else begin
        out_start  <= start_flag;
        out_active <= seen && (CW'(ticks) < CW'(hold_ticks));
        out_env    <= env_wide[LW-1:0];
        out_base   <= base_wide[LW-1:0];
      end
    end
  end

  // a taken sample closes the input until its result is handed on
  `ABD_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  // decay never raises the envelope
  `ABD_ASSERT_SAME(a_decay_down, clk, rst, state == S_BSET && $past(state) == S_DECAY,
                   env <= $past(env))
  // the baseline has been floored before the beat test
  `ABD_ASSERT_SAME(a_base_floored, clk, rst, state == S_CMP, base >= flo)
  // a beat start restarts the tick count
  `ABD_ASSERT_SAME(a_start_clears, clk, rst, state == S_OUT && start_flag,
                   ticks == '0 && seen)
  // a reported beat start is active unless the hold is zero
  `ABD_ASSERT_SAME(a_start_active, clk, rst, m_tvalid && out_start && hold_ticks != '0,
                   out_active)

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // cycles allowed for the block to settle once the last result has come back
  localparam int DRAIN_CYCLES = 40;

  // register file of the detector, one field per configuration register
  typedef struct {
    logic        en;
    logic [11:0] mid;
    logic [15:0] decay;
    logic [15:0] alpha;
    logic [11:0] ratio;
    logic [11:0] base_floor;
    logic [15:0] hold;
    logic [15:0] lockout;
  } det_cfg_t;

  // result item as packed on m_tdata, lowest bit first: start, active, envelope, baseline
  typedef struct packed {
    logic [11:0] base_level;
    logic [11:0] env_level;
    logic        active;
    logic        start;
  } beat_result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = abd_pkg::REG_ENABLE;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // sample
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;          // beat_start, beat_active, envelope_level, baseline_level

  // detector state as the testbench tracks it
  det_cfg_t     active_cfg;
  logic [19:0]  env_acc;
  logic [19:0]  base_acc;
  logic [15:0]  since_beat;
  logic         had_beat;

  beat_result_t expected_beats[$];
  int           mismatch_count = 0;

  // receiver control, shared with the test tasks
  int           hold_request = 0;
  bit           rx_stalls    = 1'b1;

  audio_beat_detector_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic det_cfg_t default_cfg();
    det_cfg_t c;
    c.en         = 1'b0;
    c.mid        = 12'(abd_pkg::MID_RAIL_RESET);
    c.decay      = 16'(abd_pkg::DECAY_FACTOR_RESET);
    c.alpha      = 16'(abd_pkg::BASE_WEIGHT_RESET);
    c.ratio      = 12'(abd_pkg::BEAT_RATIO_RESET);
    c.base_floor = 12'(abd_pkg::BASE_MIN_RESET);
    c.hold       = 16'(abd_pkg::HOLD_TICKS_RESET);
    c.lockout    = 16'(abd_pkg::LOCKOUT_TICKS_RESET);
    return c;
  endfunction

  function automatic void clear_detector();
    env_acc    = '0;
    base_acc   = 20'(abd_pkg::BASE_RESET_COUNTS) << 8;
    since_beat = '0;
    had_beat   = 1'b0;
  endfunction

  // one millisecond tick of the detector: envelope, baseline, then the beat test
  function automatic beat_result_t predict_tick(input logic [11:0] smp);
    beat_result_t r;
    logic [11:0]  amp;
    logic [19:0]  amp_q;
    logic [19:0]  floor_q;
    logic [63:0]  wide;
    r = '0;
    if (!active_cfg.en) begin
      clear_detector();
      return r;
    end
    if (had_beat && since_beat != 16'hFFFF)
      since_beat = since_beat + 16'd1;

    // instant attack, otherwise truncated decay
    amp   = (smp >= active_cfg.mid) ? smp - active_cfg.mid : active_cfg.mid - smp;
    amp_q = {amp, 8'h00};
    if (amp_q > env_acc) begin
      env_acc = amp_q;
    end else begin
      wide    = 64'(env_acc) * 64'(active_cfg.decay);
      env_acc = wide[35:16];
    end

    // slow iir of the envelope, then the floor
    wide     = (64'd65536 - 64'(active_cfg.alpha)) * 64'(base_acc)
             + 64'(active_cfg.alpha) * 64'(env_acc);
    base_acc = wide[35:16];
    floor_q  = {active_cfg.base_floor, 8'h00};
    if (base_acc < floor_q)
      base_acc = floor_q;

    // threshold in q4.8, lockout only once a beat has been seen
    if ((64'(env_acc) << 8) > 64'(base_acc) * 64'(active_cfg.ratio)
        && (!had_beat || since_beat >= active_cfg.lockout)) begin
      r.start    = 1'b1;
      had_beat   = 1'b1;
      since_beat = '0;
    end
    r.active     = had_beat && (since_beat < active_cfg.hold);
    r.env_level  = env_acc[19:8];
    r.base_level = base_acc[19:8];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking and receiver stall pattern
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic check_result(input logic [31:0] word);
    beat_result_t want;
    beat_result_t got;
    logic [abd_pkg::OUT_PAD_BITS-1:0] pad;
    got = beat_result_t'(word[$bits(beat_result_t)-1:0]);
    pad = word[abd_pkg::OUT_DATA_BITS-1 -: abd_pkg::OUT_PAD_BITS];
    if (expected_beats.size() == 0) begin
      mismatch_count++;
      $error("result item with nothing expected: %h", word);
    end else begin
      want = expected_beats.pop_front();
      if (got.start !== want.start)
        note_mismatch("beat_start", want.start, got.start);
      if (got.active !== want.active)
        note_mismatch("beat_active", want.active, got.active);
      if (got.env_level !== want.env_level)
        note_mismatch("envelope_level", want.env_level, got.env_level);
      if (got.base_level !== want.base_level)
        note_mismatch("baseline_level", want.base_level, got.base_level);
      if (pad !== '0)
        note_mismatch("tdata padding", 0, pad);
    end
  endtask

  // values read here are the ones sampled at this edge; m_tready is driven for the next
  int rx_cycle  = 0;
  int hold_left = 0;
  int stall_pct = 0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_result(m_tdata);

    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      // long hold-off: the block must fill up and stall its input
      hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_stalls) begin
      m_tready <= 1'b1;
    end else begin
      // stall rate is redrawn each time rx_cycle wraps, zero rate gives clean stretches
      if (rx_cycle == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      rx_cycle = (rx_cycle + 1) % 64;
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // valid stays high from one item to the next, only pause and idle lower it
  task automatic send_sample(input logic [11:0] smp);
    s_tdata  <= 16'(smp);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_beats.push_back(predict_tick(smp));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // holds the write enable high, the caller lowers it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // writes every register; only called with the block idle
  task automatic apply_cfg(input det_cfg_t c);
    write_reg(abd_pkg::REG_ENABLE,         16'(c.en));
    write_reg(abd_pkg::REG_MID_RAIL,       16'(c.mid));
    write_reg(abd_pkg::REG_DECAY_FACTOR,   c.decay);
    write_reg(abd_pkg::REG_BASE_WEIGHT,    c.alpha);
    write_reg(abd_pkg::REG_BEAT_RATIO,     16'(c.ratio));
    write_reg(abd_pkg::REG_BASE_MIN,       16'(c.base_floor));
    write_reg(abd_pkg::REG_HOLD_TICKS,     c.hold);
    write_reg(abd_pkg::REG_LOCKOUT_TICKS,  c.lockout);
    cfg_we     <= 1'b0;
    active_cfg  = c;
  endtask

  // sample at a signed distance from the midpoint, clipped to the adc range
  function automatic logic [11:0] offset_sample(input logic [11:0] mid, input int delta);
    int v;
    v = int'(mid) + delta;
    if (v < 0)
      v = 0;
    if (v > 4095)
      v = 4095;
    return 12'(v);
  endfunction

  function automatic int signed_amp(input int lo, input int hi);
    int d;
    d = $urandom_range(hi, lo);
    return $urandom_range(0, 1) ? d : -d;
  endfunction

  function automatic logic [15:0] rand_ticks();
    case ($urandom_range(0, 6))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 5));
      default: return 16'($urandom_range(0, 60));
    endcase
  endfunction

  // mostly settings under which beats come and go, sometimes anything at all
  function automatic det_cfg_t random_cfg();
    det_cfg_t c;
    c.en         = ($urandom_range(0, 11) != 0);
    c.mid        = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                               : offset_sample(12'd2048, signed_amp(0, 300));
    c.decay      = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(55000, 65535));
    c.alpha      = ($urandom_range(0, 4) < 2) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    c.ratio      = ($urandom_range(0, 4) < 2) ? 12'($urandom) : 12'($urandom_range(256, 1024));
    c.base_floor = ($urandom_range(0, 4) < 2) ? 12'($urandom) : 12'($urandom_range(0, 200));
    c.hold       = rand_ticks();
    c.lockout    = rand_ticks();
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // out of reset the detector is off: every result all zero
  task automatic test_disabled_after_reset();
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd2048);
    wait_idle();
  endtask

  // reset settings, enabled: quiet ticks with no beat yet, a first beat, then lockout
  task automatic test_first_beat();
    det_cfg_t c;
    c    = default_cfg();
    c.en = 1'b1;
    apply_cfg(c);
    send_sample(12'd2048);
    send_sample(12'd2048);
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd2048);
    send_sample(12'd2048);
    send_sample(12'd3000);
    wait_idle();
  endtask

  // most registers at one extreme and then the other, zero hold and zero alpha among them
  task automatic test_extreme_settings();
    det_cfg_t c;
    c.en         = 1'b1;
    c.mid        = 12'd0;
    c.decay      = 16'hFFFF;
    c.alpha      = 16'hFFFF;
    c.ratio      = 12'hFFF;
    c.base_floor = 12'hFFF;
    c.hold       = 16'd0;
    c.lockout    = 16'd0;
    apply_cfg(c);
    send_sample(12'hFFF);
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd2048);
    wait_idle();

    // ratio zero fires on any nonzero envelope, no lockout, alpha zero freezes the baseline
    c.mid        = 12'hFFF;
    c.decay      = 16'd0;
    c.alpha      = 16'd0;
    c.ratio      = 12'd0;
    c.base_floor = 12'd0;
    c.hold       = 16'hFFFF;
    c.lockout    = 16'd0;
    apply_cfg(c);
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'd0);
    send_sample(12'd0);
    send_sample(12'hFFF);
    wait_idle();
  endtask

  // a disabled tick clears the state, so re-enabling starts from reset values
  task automatic test_reenable();
    det_cfg_t c;
    c = default_cfg();
    apply_cfg(c);
    send_sample(12'd100);
    wait_idle();
    c.en = 1'b1;
    apply_cfg(c);
    send_sample(12'd2048);
    send_sample(12'd10);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while items keep being offered back to back
  task automatic test_output_backpressure();
    det_cfg_t c;
    int       n;
    c         = default_cfg();
    c.en      = 1'b1;
    c.hold    = 16'd5;
    c.lockout = 16'd8;
    apply_cfg(c);
    hold_request = 300;
    for (n = 0; n < 40; n++) begin
      if (n % 6 == 0)
        send_sample(offset_sample(c.mid, signed_amp(800, 2047)));
      else
        send_sample(offset_sample(c.mid, signed_amp(0, 30)));
    end
    wait_idle();
  endtask

  // rhythmic input: quiet noise around the midpoint broken by loud transients
  task automatic test_random_phases();
    det_cfg_t    c;
    logic [11:0] smp;
    int          burst_left;
    int          until_hit;
    int          hit_left;
    int          noise;
    rx_stalls = 1'b1;
    repeat (8) begin
      c = random_cfg();
      apply_cfg(c);
      noise      = $urandom_range(0, 80);
      until_hit  = $urandom_range(3, 30);
      hit_left   = 0;
      burst_left = 0;
      repeat (110) begin
        if (burst_left == 0) begin
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (hit_left > 0) begin
          hit_left--;
          smp = offset_sample(c.mid, signed_amp(400, 2047));
        end else if (until_hit == 0) begin
          hit_left  = $urandom_range(0, 3);
          until_hit = $urandom_range(5, 40);
          smp       = offset_sample(c.mid, signed_amp(400, 2047));
        end else begin
          until_hit--;
          if ($urandom_range(0, 9) == 0)
            smp = 12'($urandom);
          else
            smp = offset_sample(c.mid, signed_amp(0, noise));
        end
        send_sample(smp);
      end
      wait_idle();
    end
  endtask

  initial begin
    active_cfg = default_cfg();
    clear_detector();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled_after_reset();
    test_first_beat();
    test_extreme_settings();
    test_reenable();
    test_output_backpressure();
    test_random_phases();

    if (mismatch_count == 0 && expected_beats.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
